// ----- sv/ngvp_pkg.sv -----
// shared types, constants and small arithmetic helpers for the nmea gga/vtg parser
// no dependencies; used by ngvp_min_step and nmea_gga_vtg_parser_core
`timescale 1ns / 1ps

package ngvp_pkg;

  localparam int MAX_LINE = 100;

  localparam logic [1:0] MATCH_NONE = 2'b00;
  localparam logic [1:0] MATCH_GGA  = 2'b01;
  localparam logic [1:0] MATCH_VTG  = 2'b10;
  localparam logic [1:0] MATCH_BOTH = 2'b11;

  localparam logic [31:0] LAT_LIMIT   = 32'd900000000;
  localparam logic [31:0] LON_LIMIT   = 32'd1800000000;
  localparam logic [23:0] SPEED_LIMIT = 24'd9999999;
  localparam logic [19:0] MIN_INT_CAP = 20'd999999;
  localparam logic [19:0] SPD_INT_CAP = 20'd10000;

  // 999999 minutes * 1e7 / 60, remainder zero
  localparam logic [37:0] MIN_SAT_QUO = 38'd166666500000;

  typedef enum logic [1:0] {
    MIN_HOLD,
    MIN_INT,
    MIN_FRAC,
    MIN_SAT
  } min_kind_e;

  typedef struct packed {
    min_kind_e  kind;
    logic [3:0] digit;
    logic [2:0] fc;
  } min_op_t;

  typedef struct packed {
    logic [4:0] quo;
    logic [5:0] rem;
  } div60_t;

  typedef struct packed {
    logic [14:0] pq;
    logic [5:0]  pr;
  } frac_w_t;

  // exact for x below 1024
  function automatic div60_t div60(input logic [9:0] x);
    logic [20:0] prod;
    div60_t      res;
    prod    = 21'(x) * 21'd1093;
    res.quo = prod[20:16];
    res.rem = 6'(x - 10'(res.quo) * 10'd60);
    return res;
  endfunction

  // weight 10^(6-fc) split as pq*60 + pr
  function automatic frac_w_t frac_weight(input logic [2:0] fc);
    frac_w_t w;
    case (fc)
      3'd0:    w = '{pq: 15'd16666, pr: 6'd40};
      3'd1:    w = '{pq: 15'd1666,  pr: 6'd40};
      3'd2:    w = '{pq: 15'd166,   pr: 6'd40};
      3'd3:    w = '{pq: 15'd16,    pr: 6'd40};
      3'd4:    w = '{pq: 15'd1,     pr: 6'd40};
      3'd5:    w = '{pq: 15'd0,     pr: 6'd10};
      3'd6:    w = '{pq: 15'd0,     pr: 6'd1};
      default: w = '{pq: 15'd0,     pr: 6'd0};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] tag_char(input logic vtg, input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = "G";
      3'd1:    ch = "N";
      3'd2:    ch = vtg ? "V" : "G";
      3'd3:    ch = vtg ? "T" : "G";
      3'd4:    ch = vtg ? "G" : "A";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // bit 4 set when c is a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] h;
    if (c >= "0" && c <= "9") h = {1'b1, 4'(c - "0")};
    else if (c >= "A" && c <= "F") h = {1'b1, 4'(c - "A" + 8'd10)};
    else if (c >= "a" && c <= "f") h = {1'b1, 4'(c - "a" + 8'd10)};
    else h = 5'd0;
    return h;
  endfunction

endpackage

// ----- sv/nmea_gga_vtg_parser_core.sv -----
// nmea gga/vtg sentence parser top level: byte input, held fix/position/speed output
// depends on ngvp_pkg and ngvp_min_step
`timescale 1ns / 1ps

// usage
// s_axis carries one received nmea character per transfer in tdata[7:0].
// m_axis carries one result per checked GNGGA or GNVTG sentence, issued on
// the transfer of its closing line feed. tuser is the sentence kind
// (0 position, 1 speed); tdata holds the held values after the update.
// a byte passes an input register and is parsed from there; a result then
// passes the output register before it appears on m_axis.
// throughput is one byte per cycle unless the output stalls, limited by the
// per-byte update of the field scanner and minutes accumulator between the two registers.
// while a result waits in the output register with m_axis_tready low, the
// byte held in the input register is not parsed and s_axis_tready drops
// once that register is full.
// reset clears parse state and all held values to zero; bytes before the
// first '$' are ignored.
module nmea_gga_vtg_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // fix_active[0], latitude_e7[31:1], longitude_e7[63:32],
                                      // satellite_count[70:64], speed_mkmh[94:71], zero[95]
  output logic        m_axis_tuser    // sentence_kind[0]
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_CKHI,
    PH_CKLO,
    PH_TAIL
  } phase_e;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       fire;

  phase_e      phase_q, phase_d;
  logic [6:0]  line_q, line_d;
  logic [7:0]  cks_q, cks_d;
  logic [3:0]  fidx_q, fidx_d;
  logic [1:0]  match_q, match_d;
  logic [6:0]  pos_q, pos_d;
  logic [33:0] deg_q, deg_d;
  logic [19:0] int_q, int_d;
  logic [37:0] minq_q, minq_d;
  logic [5:0]  minr_q, minr_d;
  logic [2:0]  fc_q, fc_d;
  logic [9:0]  sfrac_q, sfrac_d;
  logic        dot_q, dot_d;
  logic        send_q, send_d;
  logic        stop_q, stop_d;
  logic [31:0] shlat_q, shlat_d;
  logic [31:0] shlon_q, shlon_d;
  logic        shfix_q, shfix_d;
  logic [6:0]  shsat_q, shsat_d;
  logic [23:0] shspd_q, shspd_d;
  logic [31:0] hlat_q, hlat_d;
  logic [31:0] hlon_q, hlon_d;
  logic        hfix_q, hfix_d;
  logic [6:0]  hsat_q, hsat_d;
  logic [23:0] hspd_q, hspd_d;

  logic        res_valid;
  logic        res_kind;
  logic        out_valid_q;
  logic        out_kind_q;
  logic [94:0] out_data_q;

  ngvp_pkg::min_op_t min_op;
  logic              scan_clr;
  logic [37:0]       min_quo;
  logic [5:0]        min_rem;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  ngvp_min_step u_min_step (
    .quo_i (minq_q),
    .rem_i (minr_q),
    .op_i  (min_op),
    .quo_o (min_quo),
    .rem_o (min_rem)
  );

  assign minq_d = scan_clr ? '0 : min_quo;
  assign minr_d = scan_clr ? '0 : min_rem;

  always_comb begin
    logic [7:0]  c;
    logic [3:0]  dg;
    logic        is_dig;
    logic        fend;
    logic        fchar;
    logic [23:0] int_new;
    logic [4:0]  hx;
    logic [38:0] mag;
    logic [31:0] lim;
    logic [9:0]  sats;
    logic [24:0] spd;
    logic [2:0]  degd;
    logic [9:0]  sw;
    c       = in_byte_q;
    dg      = 4'(c - 8'h30);
    is_dig  = (c >= "0") && (c <= "9");
    fend    = 1'b0;
    fchar   = 1'b0;
    int_new = 24'(int_q) * 24'd10 + 24'(dg);
    hx      = ngvp_pkg::hex_value(c);
    mag     = '0;
    lim     = '0;
    sats    = 10'(shsat_q) * 10'd10 + 10'(dg);
    spd     = '0;
    degd    = (fidx_q == 4'd2) ? 3'd2 : 3'd3;
    sw      = (fc_q == 3'd0) ? 10'd100 : ((fc_q == 3'd1) ? 10'd10 : 10'd1);

    phase_d = phase_q;  line_d = line_q;  cks_d = cks_q;  fidx_d = fidx_q;
    match_d = match_q;  pos_d = pos_q;    deg_d = deg_q;  int_d = int_q;
    fc_d = fc_q;        sfrac_d = sfrac_q; dot_d = dot_q; send_d = send_q;
    stop_d = stop_q;    shlat_d = shlat_q; shlon_d = shlon_q;
    shfix_d = shfix_q;  shsat_d = shsat_q; shspd_d = shspd_q;
    hlat_d = hlat_q;    hlon_d = hlon_q;   hfix_d = hfix_q;
    hsat_d = hsat_q;    hspd_d = hspd_q;
    min_op    = '{kind: ngvp_pkg::MIN_HOLD, digit: dg, fc: fc_q};
    scan_clr  = 1'b0;
    res_valid = 1'b0;
    res_kind  = 1'b0;

    if (fire) begin
      if (c == "$") begin
        phase_d = PH_BODY;  line_d = 7'd1;  cks_d = '0;  fidx_d = '0;
        match_d = ngvp_pkg::MATCH_BOTH;
        shlat_d = '0;  shlon_d = '0;  shfix_d = 1'b0;  shsat_d = '0;  shspd_d = '0;
        stop_d  = 1'b0;
        scan_clr = 1'b1;
      end else if (phase_q != PH_IDLE) begin
        if (line_q >= 7'(ngvp_pkg::MAX_LINE)) begin
          phase_d = PH_IDLE;
        end else begin
          line_d = line_q + 7'd1;
          case (phase_q)
            PH_BODY: begin
              if (c == 8'h0d || c == 8'h0a) begin
                phase_d = PH_IDLE;
              end else if (c == "*") begin
                fend    = 1'b1;
                phase_d = PH_CKHI;
              end else begin
                cks_d = cks_q ^ c;
                if (c == ",") fend = 1'b1;
                else fchar = 1'b1;
              end
            end
            PH_CKHI: phase_d = (hx[4] && hx[3:0] == cks_q[7:4]) ? PH_CKLO : PH_IDLE;
            PH_CKLO: phase_d = (hx[4] && hx[3:0] == cks_q[3:0]) ? PH_TAIL : PH_IDLE;
            PH_TAIL: begin
              if (c != 8'h0d) begin
                phase_d = PH_IDLE;
                if (c == 8'h0a) begin
                  if (match_q == ngvp_pkg::MATCH_GGA) begin
                    hfix_d = shfix_q;
                    hsat_d = shsat_q;
                    if (shfix_q) begin
                      hlat_d = shlat_q;
                      hlon_d = shlon_q;
                    end
                    res_valid = 1'b1;
                    res_kind  = 1'b0;
                  end else if (match_q == ngvp_pkg::MATCH_VTG) begin
                    hspd_d    = shspd_q;
                    res_valid = 1'b1;
                    res_kind  = 1'b1;
                  end
                end
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end

      if (fchar) begin
        if (fidx_q == 4'd0) begin
          if (pos_q < 7'd5) begin
            if (c != ngvp_pkg::tag_char(1'b0, pos_q[2:0])) match_d[0] = 1'b0;
            if (c != ngvp_pkg::tag_char(1'b1, pos_q[2:0])) match_d[1] = 1'b0;
          end else begin
            match_d = ngvp_pkg::MATCH_NONE;
          end
        end else if (match_q == ngvp_pkg::MATCH_GGA && !stop_q) begin
          case (fidx_q)
            4'd2, 4'd4: begin
              if (pos_q < 7'(degd)) begin
                if (!send_q) begin
                  if (is_dig) deg_d = 34'(deg_q * 34'd10 + 34'(dg) * 34'd10000000);
                  else send_d = 1'b1;
                end
              end else if (!send_q) begin
                if (is_dig) begin
                  if (dot_q) begin
                    if (fc_q < 3'd7) begin
                      min_op.kind = ngvp_pkg::MIN_FRAC;
                      fc_d        = fc_q + 3'd1;
                    end
                  end else if (int_new > 24'(ngvp_pkg::MIN_INT_CAP)) begin
                    int_d       = ngvp_pkg::MIN_INT_CAP;
                    min_op.kind = ngvp_pkg::MIN_SAT;
                  end else begin
                    int_d       = int_new[19:0];
                    min_op.kind = ngvp_pkg::MIN_INT;
                  end
                end else if (c == "." && !dot_q) begin
                  dot_d = 1'b1;
                end else begin
                  send_d = 1'b1;
                end
              end
            end
            4'd3: if (pos_q == 7'd0 && c == "S") shlat_d = 32'd0 - shlat_q;
            4'd5: if (pos_q == 7'd0 && c == "W") shlon_d = 32'd0 - shlon_q;
            4'd6, 4'd7: begin
              if (!send_q) begin
                if (is_dig) begin
                  if (fidx_q == 4'd6) begin
                    if (c != "0") shfix_d = 1'b1;
                  end else begin
                    shsat_d = (sats > 10'd99) ? 7'd99 : sats[6:0];
                  end
                end else if (pos_q == 7'd0) begin
                  stop_d = 1'b1;
                end else begin
                  send_d = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end else if (match_q == ngvp_pkg::MATCH_VTG && fidx_q == 4'd7) begin
          if (!send_q) begin
            if (is_dig) begin
              if (dot_q) begin
                if (fc_q < 3'd3) begin
                  sfrac_d = sfrac_q + 10'(dg) * sw;
                  fc_d    = fc_q + 3'd1;
                end
              end else if (int_new > 24'(ngvp_pkg::SPD_INT_CAP)) begin
                int_d = ngvp_pkg::SPD_INT_CAP;
              end else begin
                int_d = int_new[19:0];
              end
            end else if (c == "." && !dot_q) begin
              dot_d = 1'b1;
            end else begin
              send_d = 1'b1;
            end
          end
        end
        if (pos_q < 7'd127) pos_d = pos_q + 7'd1;
      end

      if (fend) begin
        if (fidx_q == 4'd0) begin
          if (pos_q != 7'd5) match_d = ngvp_pkg::MATCH_NONE;
        end else if (match_q == ngvp_pkg::MATCH_GGA && !stop_q && fidx_q <= 4'd7) begin
          lim = (fidx_q == 4'd2) ? ngvp_pkg::LAT_LIMIT : ngvp_pkg::LON_LIMIT;
          mag = 39'(deg_q) + 39'(minq_q) + 39'(minr_q >= 6'd30);
          if (pos_q == 7'd0) stop_d = 1'b1;
          else if (fidx_q == 4'd2) shlat_d = (mag > 39'(lim)) ? lim : mag[31:0];
          else if (fidx_q == 4'd4) shlon_d = (mag > 39'(lim)) ? lim : mag[31:0];
        end else if (match_q == ngvp_pkg::MATCH_VTG && fidx_q == 4'd7) begin
          spd     = 25'(int_q) * 25'd1000 + 25'(sfrac_q);
          shspd_d = (spd > 25'(ngvp_pkg::SPEED_LIMIT)) ? ngvp_pkg::SPEED_LIMIT : spd[23:0];
        end
        if (fidx_q < 4'd15) fidx_d = fidx_q + 4'd1;
        scan_clr = 1'b1;
      end

      if (scan_clr) begin
        pos_d = '0;  deg_d = '0;  int_d = '0;  fc_d = '0;  sfrac_d = '0;
        dot_d = 1'b0;  send_d = 1'b0;
        min_op.kind = ngvp_pkg::MIN_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q <= PH_IDLE;  line_q <= '0;  cks_q <= '0;  fidx_q <= '0;
      match_q <= ngvp_pkg::MATCH_NONE;  pos_q <= '0;  deg_q <= '0;  int_q <= '0;
      minq_q <= '0;  minr_q <= '0;  fc_q <= '0;  sfrac_q <= '0;
      dot_q <= 1'b0;  send_q <= 1'b0;  stop_q <= 1'b0;
      shlat_q <= '0;  shlon_q <= '0;  shfix_q <= 1'b0;  shsat_q <= '0;  shspd_q <= '0;
      hlat_q <= '0;  hlon_q <= '0;  hfix_q <= 1'b0;  hsat_q <= '0;  hspd_q <= '0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (fire && res_valid) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      phase_q <= phase_d;  line_q <= line_d;  cks_q <= cks_d;  fidx_q <= fidx_d;
      match_q <= match_d;  pos_q <= pos_d;  deg_q <= deg_d;  int_q <= int_d;
      minq_q <= minq_d;  minr_q <= minr_d;  fc_q <= fc_d;  sfrac_q <= sfrac_d;
      dot_q <= dot_d;  send_q <= send_d;  stop_q <= stop_d;
      shlat_q <= shlat_d;  shlon_q <= shlon_d;  shfix_q <= shfix_d;
      shsat_q <= shsat_d;  shspd_q <= shspd_d;
      hlat_q <= hlat_d;  hlon_q <= hlon_d;  hfix_q <= hfix_d;
      hsat_q <= hsat_d;  hspd_q <= hspd_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_byte_q <= s_axis_tdata;
    if (fire && res_valid) begin
      out_kind_q <= res_kind;
      out_data_q <= {hspd_d, hsat_d, hlon_d, hlat_d[30:0], hfix_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

endmodule

// ----- sv/ngvp_min_step.sv -----
// minutes accumulator step: keeps minutes*1e7 as quotient and remainder by 60
// depends on ngvp_pkg
`timescale 1ns / 1ps

module ngvp_min_step (
  input  logic [37:0]      quo_i,
  input  logic [5:0]       rem_i,
  input  ngvp_pkg::min_op_t op_i,
  output logic [37:0]      quo_o,
  output logic [5:0]       rem_o
);

  always_comb begin
    logic [9:0]            x;
    ngvp_pkg::div60_t      dv;
    ngvp_pkg::frac_w_t     w;
    logic [40:0]           q_wide;
    x      = '0;
    dv     = '0;
    w      = ngvp_pkg::frac_weight(op_i.fc);
    q_wide = 41'(quo_i);
    quo_o  = quo_i;
    rem_o  = rem_i;
    case (op_i.kind)
      ngvp_pkg::MIN_INT: begin
        // 1e7 = 166666*60 + 40
        x      = 10'(rem_i) * 10'd10 + 10'(op_i.digit) * 10'd40;
        dv     = ngvp_pkg::div60(x);
        q_wide = 41'(quo_i) * 41'd10 + 41'(op_i.digit) * 41'd166666 + 41'(dv.quo);
        quo_o  = q_wide[37:0];
        rem_o  = dv.rem;
      end
      ngvp_pkg::MIN_FRAC: begin
        x      = 10'(rem_i) + 10'(op_i.digit) * 10'(w.pr);
        dv     = ngvp_pkg::div60(x);
        q_wide = 41'(quo_i) + 41'(op_i.digit) * 41'(w.pq) + 41'(dv.quo);
        quo_o  = q_wide[37:0];
        rem_o  = dv.rem;
      end
      ngvp_pkg::MIN_SAT: begin
        quo_o = ngvp_pkg::MIN_SAT_QUO;
        rem_o = '0;
      end
      default: begin
        quo_o = quo_i;
        rem_o = rem_i;
      end
    endcase
  end

endmodule

// ----- bench/nmea_parser_checker.sv -----
// checker for nmea_gga_vtg_parser_core: predicts held gga/vtg values per sentence and
// compares each m_axis transfer; depends on ngvp_pkg for limits and match codes
`timescale 1ns / 1ps

module nmea_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_BODY, PH_CKHI, PH_CKLO, PH_TAIL
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic        fix;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [6:0]  sats;
    logic [23:0] speed;
  } fix_report_t;

  fix_report_t report_q[$];

  int unsigned line_len, field_idx, pos, acc_deg, acc_int, acc_frac, frac_cnt;
  logic [7:0]  cksum;
  phase_e      phase;
  logic [1:0]  tmatch;
  logic [31:0] sh_lat, sh_lon, sh_misc, hd_lat, hd_lon, hd_speed;
  logic [7:0]  hd_fs;
  bit          dot_seen, scan_end, stopped;

  assign pending_o = report_q.size();

  function automatic int hexv(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic bit isdig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] tagc(input bit vtg, input int p);
    string s;
    s = vtg ? "GNVTG" : "GNGGA";
    return s[p];
  endfunction

  task automatic clear_scan();
    pos = 0; acc_deg = 0; acc_int = 0; acc_frac = 0; frac_cnt = 0;
    dot_seen = 0; scan_end = 0;
  endtask

  task automatic scan_dec(input logic [7:0] c, input int unsigned cap, input int unsigned fmax);
    if (scan_end) return;
    if (isdig(c)) begin
      if (dot_seen) begin
        if (frac_cnt < fmax) begin
          acc_frac = acc_frac * 10 + (c - "0");
          frac_cnt++;
        end
      end else begin
        acc_int = acc_int * 10 + (c - "0");
        if (acc_int > cap) acc_int = cap;
      end
    end else if (c == "." && !dot_seen) dot_seen = 1;
    else scan_end = 1;
  endtask

  task automatic scan_coord(input logic [7:0] c, input int unsigned ndeg);
    if (pos < ndeg) begin
      if (scan_end) return;
      if (isdig(c)) acc_deg = acc_deg * 10 + (c - "0");
      else scan_end = 1;
    end else scan_dec(c, 999999, 7);
  endtask

  function automatic logic [31:0] coord_mag(input longint unsigned lim);
    longint unsigned mins, mag, p10;
    p10 = 1;
    repeat (7 - frac_cnt) p10 *= 10;
    mins = longint'(acc_int) * 10000000 + longint'(acc_frac) * p10;
    mag = longint'(acc_deg) * 10000000 + (mins + 30) / 60;
    return (mag > lim) ? lim[31:0] : mag[31:0];
  endfunction

  task automatic on_char(input logic [7:0] c);
    int unsigned s;
    if (field_idx == 0) begin
      if (pos < 5) begin
        if (c != tagc(0, pos)) tmatch &= ~ngvp_pkg::MATCH_GGA;
        if (c != tagc(1, pos)) tmatch &= ~ngvp_pkg::MATCH_VTG;
      end else tmatch = ngvp_pkg::MATCH_NONE;
    end else if (tmatch == ngvp_pkg::MATCH_GGA && !stopped) begin
      case (field_idx)
        2: scan_coord(c, 2);
        4: scan_coord(c, 3);
        3: if (pos == 0 && c == "S") sh_lat = -sh_lat;
        5: if (pos == 0 && c == "W") sh_lon = -sh_lon;
        6, 7: if (!scan_end) begin
          if (isdig(c)) begin
            if (field_idx == 6) begin
              if (c != "0") sh_misc[0] = 1;
            end else begin
              s = sh_misc[7:1] * 10 + (c - "0");
              if (s > 99) s = 99;
              sh_misc[7:1] = s[6:0];
            end
          end else if (pos == 0) stopped = 1;
          else scan_end = 1;
        end
        default: ;
      endcase
    end else if (tmatch == ngvp_pkg::MATCH_VTG && field_idx == 7) begin
      scan_dec(c, ngvp_pkg::SPD_INT_CAP, 3);
    end
    if (pos < 127) pos++;
  endtask

  task automatic on_field_end();
    longint unsigned v, p10;
    if (field_idx == 0) begin
      if (pos != 5) tmatch = ngvp_pkg::MATCH_NONE;
    end else if (tmatch == ngvp_pkg::MATCH_GGA && !stopped && field_idx <= 7) begin
      if (pos == 0) stopped = 1;
      else if (field_idx == 2) sh_lat = coord_mag(ngvp_pkg::LAT_LIMIT);
      else if (field_idx == 4) sh_lon = coord_mag(ngvp_pkg::LON_LIMIT);
    end else if (tmatch == ngvp_pkg::MATCH_VTG && field_idx == 7) begin
      p10 = 1;
      repeat (3 - frac_cnt) p10 *= 10;
      v = longint'(acc_int) * 1000 + longint'(acc_frac) * p10;
      if (v > ngvp_pkg::SPEED_LIMIT) v = ngvp_pkg::SPEED_LIMIT;
      sh_misc[31:8] = v[23:0];
    end
    if (field_idx < 15) field_idx++;
    clear_scan();
  endtask

  task automatic predict_byte(input logic [7:0] c);
    fix_report_t r;
    int h;
    if (c == "$") begin
      phase = PH_BODY; line_len = 1; cksum = 0; field_idx = 0;
      tmatch = ngvp_pkg::MATCH_BOTH;
      sh_lat = 0; sh_lon = 0; sh_misc = 0; stopped = 0;
      clear_scan();
      return;
    end
    if (phase == PH_IDLE) return;
    if (line_len >= ngvp_pkg::MAX_LINE) begin
      phase = PH_IDLE;
      return;
    end
    line_len++;
    case (phase)
      PH_BODY: begin
        if (c == "\r" || c == "\n") phase = PH_IDLE;
        else if (c == "*") begin
          on_field_end();
          phase = PH_CKHI;
        end else begin
          cksum ^= c;
          if (c == ",") on_field_end(); else on_char(c);
        end
      end
      PH_CKHI: begin
        h = hexv(c);
        phase = (h == cksum[7:4]) ? PH_CKLO : PH_IDLE;
      end
      PH_CKLO: begin
        h = hexv(c);
        phase = (h == cksum[3:0]) ? PH_TAIL : PH_IDLE;
      end
      PH_TAIL: if (c != "\r") begin
        phase = PH_IDLE;
        if (c == "\n" &&
            (tmatch == ngvp_pkg::MATCH_GGA || tmatch == ngvp_pkg::MATCH_VTG)) begin
          if (tmatch == ngvp_pkg::MATCH_GGA) begin
            hd_fs = {sh_misc[0], sh_misc[7:1]};
            if (sh_misc[0]) begin
              hd_lat = sh_lat;
              hd_lon = sh_lon;
            end
          end else hd_speed = sh_misc[31:8];
          r.kind = (tmatch == ngvp_pkg::MATCH_VTG);
          r.fix = hd_fs[7];
          r.lat = hd_lat[30:0];
          r.lon = hd_lon;
          r.sats = hd_fs[6:0];
          r.speed = hd_speed[23:0];
          report_q.push_back(r);
        end
      end
      default: phase = PH_IDLE;
    endcase
  endtask

  task automatic check_report();
    fix_report_t e;
    if (report_q.size() == 0) begin
      $error("result with no sentence pending: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
      fail_count_o++;
      return;
    end
    e = report_q.pop_front();
    if (m_axis_tuser !== e.kind) begin
      $error("sentence_kind expected %0d actual %0d", e.kind, m_axis_tuser);
      fail_count_o++;
    end
    if (m_axis_tdata[0] !== e.fix) begin
      $error("fix_active expected %0d actual %0d", e.fix, m_axis_tdata[0]);
      fail_count_o++;
    end
    if (m_axis_tdata[31:1] !== e.lat) begin
      $error("latitude_e7 expected %h actual %h", e.lat, m_axis_tdata[31:1]);
      fail_count_o++;
    end
    if (m_axis_tdata[63:32] !== e.lon) begin
      $error("longitude_e7 expected %h actual %h", e.lon, m_axis_tdata[63:32]);
      fail_count_o++;
    end
    if (m_axis_tdata[70:64] !== e.sats) begin
      $error("satellite_count expected %0d actual %0d", e.sats, m_axis_tdata[70:64]);
      fail_count_o++;
    end
    if (m_axis_tdata[94:71] !== e.speed) begin
      $error("speed_mkmh expected %0d actual %0d", e.speed, m_axis_tdata[94:71]);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      fail_count_o = 0;
      phase = PH_IDLE; line_len = 0; cksum = 0; field_idx = 0;
      tmatch = ngvp_pkg::MATCH_NONE;
      sh_lat = 0; sh_lon = 0; sh_misc = 0; hd_lat = 0; hd_lon = 0; hd_fs = 0; hd_speed = 0;
      stopped = 0;
      clear_scan();
      report_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_report();
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
    end
  end
endmodule

// ----- bench/tb.sv -----
// top of the nmea parser bench: builds sentences, drives s_axis with random gaps,
// stalls m_axis and reports the verdict; depends on nmea_parser_checker and the core
`timescale 1ns / 1ps

module tb;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count, pending;
  int          cycle_cnt = 0;
  bit          calm;

  localparam int CYCLE_LIMIT = 400000;

  nmea_gga_vtg_parser_core dut (.*);

  nmea_parser_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 8);
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  // tvalid stays high between back-to-back bytes and drops only for a gap
  task automatic send_byte(input logic [7:0] b);
    int n;
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 0;
      n = $urandom_range(1, 8);
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic string hex2(input logic [7:0] v, input bit lower);
    string s;
    s = $sformatf("%02h", v);
    if (!lower) s = s.toupper();
    return s;
  endfunction

  // frames a body with checksum; corrupt flips the checksum
  task automatic send_sentence(input string body, input bit corrupt, input bit crlf);
    logic [7:0] ck;
    string full;
    ck = 0;
    for (int i = 0; i < body.len(); i++) ck ^= body[i];
    if (corrupt) ck ^= 8'(1 << $urandom_range(0, 7));
    full = {"$", body, "*", hex2(ck, $urandom_range(0, 1)), crlf ? "\r\n" : "\n"};
    for (int i = 0; i < full.len(); i++) send_byte(full[i]);
  endtask

  function automatic string digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rnd_num(input int ni, input int nf);
    string s;
    s = digits(ni);
    if ($urandom_range(0, 3) != 0) s = {s, ".", digits(nf)};
    return s;
  endfunction

  function automatic string junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == "$" || c == "*" || c == "," || c == "\r" || c == "\n") c = "-";
    return string'(c);
  endfunction

  function automatic string rnd_gga();
    string f[7];
    string s;
    f[0] = "123519";
    f[1] = {digits(2), rnd_num($urandom_range(1, 8), $urandom_range(0, 9))};
    f[2] = $urandom_range(0, 1) ? "S" : "N";
    f[3] = {digits(3), rnd_num($urandom_range(1, 8), $urandom_range(0, 9))};
    f[4] = $urandom_range(0, 1) ? "W" : "E";
    f[5] = $urandom_range(0, 3) == 0 ? "0" : digits(1);
    f[6] = digits($urandom_range(1, 3));
    if ($urandom_range(0, 5) == 0) f[$urandom_range(1, 6)] = "";
    if ($urandom_range(0, 5) == 0) f[$urandom_range(1, 6)] = {junk_char(), digits(2)};
    s = "GNGGA";
    for (int i = 0; i < 7; i++) s = {s, ",", f[i]};
    if ($urandom_range(0, 1)) s = {s, ",0.9,545.4,M,46.9,M,,"};
    return s;
  endfunction

  function automatic string rnd_vtg();
    string sp;
    sp = rnd_num($urandom_range(0, 6), $urandom_range(0, 5));
    if ($urandom_range(0, 7) == 0) sp = {sp, junk_char()};
    return {"GNVTG,054.7,T,034.4,M,005.5,N,", sp, ",K"};
  endfunction

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    string s;
    int k;
    calm = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    repeat (2) @(negedge clk_i);

    // directed: extremes, saturation, hemispheres, empty fields, bad checks
    send_byte("x");
    send_sentence("GNGGA,0,9959.9999999,S,17959.9999999,W,1,12", 0, 1);
    send_sentence("GNGGA,0,9999.99999999,N,99999.9,E,9,999", 0, 0);
    send_sentence("GNGGA,0,0000.0000000,N,00000.0000000,E,1,00", 0, 1);
    send_sentence("GNGGA,0,1234.5,S,12345.6,W,0,07", 0, 1);
    send_sentence("GNGGA,0,1234.5,S,,W,1,07", 0, 1);
    send_sentence("GNGGA,0,4807.038,N,01131.000,E,x,08", 0, 1);
    send_sentence("GNGGA,0,-807.038,N,0113.1.000,E,1,0x8", 0, 1);
    send_sentence("GNGGA,0,1234.5", 0, 1);
    send_sentence("GNVTG,1,T,2,M,3,N,99999.9999,K", 0, 1);
    send_sentence("GNVTG,1,T,2,M,3,N,0.5,K", 0, 0);
    send_sentence("GNVTG,1,T,2,M,3,N,,K", 0, 1);
    send_sentence("GPGGA,0,1234.5,N,12345.6,E,1,07", 0, 1);
    send_sentence("GNVTGX,1,T,2,M,3,N,5.5,K", 0, 1);
    send_sentence("GNVTG,1,T,2,M,3,N,5.5,K", 1, 1);
    send_byte("$"); send_sentence("GNVTG,1,T,2,M,3,N,7.25,K", 0, 1);
    s = "GNVTG,";
    for (int i = 0; i < 100; i++) s = {s, "0"};
    send_sentence(s, 0, 1);
    send_noise(8);

    // pause until all results are out
    s_axis_tvalid <= 0;
    calm = 1;
    while (pending != 0) @(negedge clk_i);
    calm = 0;

    k = 0;
    while (k < 900) begin
      if (k > 750) calm = 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: s = rnd_gga();
        4, 5, 6: s = rnd_vtg();
        7: s = {"GNGG", junk_char(), ",1,2"};
        default: s = "";
      endcase
      if (s == "") begin
        send_noise($urandom_range(1, 12));
        k += 6;
      end else begin
        send_sentence(s, $urandom_range(0, 9) == 0, $urandom_range(0, 1));
        k += s.len() + 5;
      end
    end

    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
